FILE: design/hpm_pkg.sv
// Shared types and constants for the Hall phase timing monitor.
// No dependencies; imported by the event queue and the top level.
`timescale 1ns / 1ps

package hpm_pkg;

   // Register map, indexed by word address
   localparam logic [1:0] REG_TIME_BASE_PERIOD   = 2'd0;
   localparam logic [1:0] REG_SUBDIVISION_LENGTH = 2'd1;
   localparam logic [1:0] REG_STALL_SUBDIVISIONS = 2'd2;

   // Reset values of registers and counters
   localparam logic [15:0] TIME_BASE_PERIOD_RST   = 16'd2656;
   localparam logic [7:0]  SUBDIVISION_LENGTH_RST = 8'd10;
   localparam logic [7:0]  STALL_SUBDIVISIONS_RST = 8'd255;
   localparam logic [2:0]  HALL_RST               = 3'd0;

   // Event codes on the response channel
   typedef enum logic [1:0] {
      EV_BASE  = 2'd0,
      EV_STOP  = 2'd1,
      EV_PHASE = 2'd2
   } event_kind_type;

   // Bit positions in an event mask, in delivery order
   localparam int EV_BIT_BASE  = 0;
   localparam int EV_BIT_STOP  = 1;
   localparam int EV_BIT_PHASE = 2;

   // All events raised by one request
   typedef struct packed {
      logic [2:0] mask;
      logic [2:0] hall;
      logic [7:0] travel;
   } event_set_type;

endpackage

FILE: design/hall_phase_timing_monitor.sv
// Top level of the Hall phase timing monitor: counters, registers, APB port.
// Depends on hpm_pkg and hpm_event_queue.
`timescale 1ns / 1ps

// Each request is one PWM tick with the Hall sensor state. The counter update
// for a tick happens in the cycle the request is accepted, so a tick that
// raises no event needs no queue entry, and requests may follow back to back.
// A tick raises up to three responses (time base, motion stopped, phase
// change, in that order, the final one flagged by rsp_last); they leave one
// per cycle while rsp_ready is high, from a two-entry event queue.
// req_ready drops only while both queue entries are held.
// Registers (APB, word addresses 0x0, 0x4, 0x8): time base period, subdivision
// length, stall subdivisions; a new value is used at the next reload.

module hall_phase_timing_monitor
   import hpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_hall_state,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [2:0]  rsp_new_hall,
   output logic [7:0]  rsp_travel_time,
   output logic        rsp_last,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] period_ff;
   logic [7:0]  sub_len_ff;
   logic [7:0]  stall_sub_ff;

   logic [15:0] base_ff, base_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  travel_ff, travel_in;
   logic [7:0]  stall_ff, stall_in;
   logic [2:0]  prev_hall_ff;

   logic [15:0] base_dec;
   logic [7:0]  sub_dec;
   logic [7:0]  stall_dec;
   logic [7:0]  travel_adv;
   logic [7:0]  stall_adv;
   logic        base_hit;
   logic        sub_hit;
   logic        stall_hit;
   logic        phase_hit;
   logic        accept;
   logic        queue_full;
   logic        cfg_write;
   event_set_type tick_events;

   // APB register access
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= TIME_BASE_PERIOD_RST;
         sub_len_ff   <= SUBDIVISION_LENGTH_RST;
         stall_sub_ff <= STALL_SUBDIVISIONS_RST;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_TIME_BASE_PERIOD:   period_ff    <= pwdata[15:0];
            REG_SUBDIVISION_LENGTH: sub_len_ff   <= pwdata[7:0];
            REG_STALL_SUBDIVISIONS: stall_sub_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_TIME_BASE_PERIOD:   prdata = {16'd0, period_ff};
         REG_SUBDIVISION_LENGTH: prdata = {24'd0, sub_len_ff};
         REG_STALL_SUBDIVISIONS: prdata = {24'd0, stall_sub_ff};
         default:                prdata = 32'd0;
      endcase
   end

   // Tick evaluation: time base, subdivision prescaler, travel and stall
   assign base_dec  = base_ff - 16'd1;
   assign base_hit  = (base_dec == 16'd0);
   assign base_in   = base_hit ? period_ff : base_dec;

   assign sub_dec   = sub_ff - 8'd1;
   assign sub_hit   = (sub_dec == 8'd0);
   assign sub_in    = sub_hit ? sub_len_ff : sub_dec;

   assign stall_dec = stall_ff - 8'd1;
   assign stall_hit = sub_hit && (stall_dec == 8'd0);

   always_comb begin
      travel_adv = travel_ff;
      stall_adv  = stall_ff;
      if (sub_hit) begin
         // hold travel at zero, otherwise count down
         if (travel_ff != 8'd0) begin
            travel_adv = travel_ff - 8'd1;
         end
         stall_adv = stall_hit ? stall_sub_ff : stall_dec;
      end
   end

   // Phase change reloads both subdivision counters
   assign phase_hit = (req_hall_state != prev_hall_ff);
   assign travel_in = phase_hit ? stall_sub_ff : travel_adv;
   assign stall_in  = phase_hit ? stall_sub_ff : stall_adv;

   always_comb begin
      tick_events = '0;
      tick_events.mask[EV_BIT_BASE]  = base_hit;
      tick_events.mask[EV_BIT_STOP]  = stall_hit;
      tick_events.mask[EV_BIT_PHASE] = phase_hit;
      tick_events.hall   = req_hall_state;
      tick_events.travel = travel_adv;
   end

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Commit counter state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= TIME_BASE_PERIOD_RST;
         sub_ff       <= SUBDIVISION_LENGTH_RST;
         travel_ff    <= STALL_SUBDIVISIONS_RST;
         stall_ff     <= STALL_SUBDIVISIONS_RST;
         prev_hall_ff <= HALL_RST;
      end else if (accept) begin
         base_ff      <= base_in;
         sub_ff       <= sub_in;
         travel_ff    <= travel_in;
         stall_ff     <= stall_in;
         prev_hall_ff <= req_hall_state;
      end
   end

   // Queue events and drain them one per response
   hpm_event_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (accept && (tick_events.mask != 3'd0)),
      .push_data       (tick_events),
      .full            (queue_full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_new_hall    (rsp_new_hall),
      .rsp_travel_time (rsp_travel_time),
      .rsp_last        (rsp_last)
   );

   // Checks
   a_stop_needs_sub: assert property (@(posedge clock) disable iff (reset)
      stall_hit |-> sub_hit)
      else $error("stop event without subdivision tick");

   a_hall_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (prev_hall_ff == $past(req_hall_state)))
      else $error("previous Hall state not captured");

   a_phase_reload: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_hit) |=> (travel_ff == $past(stall_sub_ff)
                                 && stall_ff == $past(stall_sub_ff)))
      else $error("counters not reloaded on phase change");

endmodule

FILE: design/hpm_event_queue.sv
// Two-entry queue of event sets; serializes each set into single responses.
// Depends on hpm_pkg.
`timescale 1ns / 1ps

module hpm_event_queue
   import hpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  event_set_type push_data,
   output logic          full,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_event_kind,
   output logic [2:0]    rsp_new_hall,
   output logic [7:0]    rsp_travel_time,
   output logic          rsp_last
);

   event_set_type entry0_ff, entry0_in;
   event_set_type entry1_ff, entry1_in;
   logic [1:0]    count_ff, count_in;
   logic [2:0]    low_bit;
   logic [2:0]    head_rest;
   logic          pop_event;
   logic          head_done;
   logic [1:0]    wr_slot;
   event_kind_type kind;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop_event = rsp_valid && rsp_ready;

   // Pick the earliest pending event of the head set
   always_comb begin
      priority if (entry0_ff.mask[EV_BIT_BASE]) begin
         low_bit = 3'b001;
         kind    = EV_BASE;
      end else if (entry0_ff.mask[EV_BIT_STOP]) begin
         low_bit = 3'b010;
         kind    = EV_STOP;
      end else begin
         low_bit = 3'b100;
         kind    = EV_PHASE;
      end
   end

   assign head_rest = entry0_ff.mask & ~low_bit;
   assign head_done = pop_event && (head_rest == 3'd0);

   // Drive the response fields
   assign rsp_event_kind  = kind;
   assign rsp_new_hall    = (kind == EV_PHASE) ? entry0_ff.hall : 3'd0;
   assign rsp_travel_time = (kind == EV_PHASE) ? entry0_ff.travel : 8'd0;
   assign rsp_last        = (head_rest == 3'd0);

   // Advance head, shift on completion, write new set behind the survivors
   assign wr_slot = count_ff - {1'b0, head_done};

   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      if (pop_event) begin
         entry0_in.mask = head_rest;
      end
      if (head_done) begin
         entry0_in = entry1_ff;
      end
      if (push) begin
         if (wr_slot[0]) begin
            entry1_in = push_data;
         end else begin
            entry0_in = push_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, head_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("event queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("event set pushed into full queue");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (entry0_ff.mask != 3'd0))
      else $error("head entry has no pending event");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (head_done && count_ff == 2'd1 && !push) |=> !rsp_valid)
      else $error("queue not empty after last event drained");

   a_partial_stays: assert property (@(posedge clock) disable iff (reset)
      (pop_event && !rsp_last) |=> rsp_valid)
      else $error("response lost before last event of request");

endmodule
